FILE: rtl/lgrt_pkg.sv
// Shared types, constants and codes for the lock grant/revoke table.
package lgrt_pkg;

  // Table geometry
  localparam int LOCK_COUNT  = 64;
  localparam int CLIENT_BITS = 8;
  localparam int WAIT_DEPTH  = 8;

  // Derived widths
  localparam int LOCK_AW = $clog2(LOCK_COUNT);
  localparam int CW      = (CLIENT_BITS < 8) ? CLIENT_BITS : 8;
  localparam int HEAD_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W   = $clog2(WAIT_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;

  // Request kinds
  localparam logic [1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_STAT    = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RETRY   = 2'd1;
  localparam logic [1:0] STATUS_NO_LOCK = 2'd2;
  localparam logic [1:0] STATUS_FREE    = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] client;
    logic [5:0] lock_index;
  } lgrt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       locked;
    logic       revoke_valid;
    logic [7:0] revoke_client;
    logic       retry_valid;
    logic [7:0] retry_client;
    logic       queue_full;
  } lgrt_out_t;

  // Per-lock bookkeeping word
  typedef struct packed {
    logic              known;
    logic              held;
    logic              pending;
    logic [CW-1:0]     holder;
    logic [HEAD_W-1:0] head;
    logic [CNT_W-1:0]  count;
  } lgrt_entry_t;

  // One lock's waiter FIFO slots
  typedef logic [WAIT_DEPTH-1:0][CW-1:0] lgrt_row_t;

endpackage

FILE: rtl/lgrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lgrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lock_grant_revoke_table_unit.sv
// Lock grant/revoke table: per-lock holder, revoke mark and waiter FIFO.
//
// Each request (acquire, release, stat) is a read-modify-write: the accept edge
// reads the lock's bookkeeping word and its waiter row from two RAMs, and once
// the result register is free or draining, an edge writes changed words back
// and loads the result register. So one item is in flight at a time: no new
// item is taken until the current one has moved to the result register. After
// reset the block sweeps all LOCK_COUNT (64) lock table entries to zero, one
// entry per cycle, with in_ready low. A result waits in the output register
// while the next item is accepted.
module lock_grant_revoke_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lgrt_pkg::lgrt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lgrt_pkg::lgrt_out_t out_data
);
  import lgrt_pkg::*;

  logic               clr_active_r;
  logic [LOCK_AW-1:0] clr_addr_r;
  logic               s1_valid_r;
  lgrt_in_t           req_r;
  logic               out_valid_r;
  lgrt_out_t          out_r;

  logic               in_accept;
  logic               s1_adv;
  lgrt_entry_t        ent;
  lgrt_entry_t        ent_nxt;
  lgrt_row_t          row;
  lgrt_row_t          row_nxt;
  logic               lock_we;
  logic               row_we;
  lgrt_out_t          res;
  logic [CW-1:0]      who;
  logic               idx_ok;
  logic [LOCK_AW-1:0] req_addr;
  logic [SUM_W-1:0]   enq_sum;
  logic [SUM_W-1:0]   deq_sum;
  logic [HEAD_W-1:0]  enq_slot;
  logic [HEAD_W-1:0]  deq_head;

  logic               tbl_we;
  logic [LOCK_AW-1:0] tbl_waddr;
  lgrt_entry_t        tbl_wdata;

  // Handshakes
  assign in_ready  = !clr_active_r && !s1_valid_r;
  assign in_accept = in_valid && in_ready;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Clear the lock table after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LOCK_AW'(LOCK_COUNT - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Hold the request while its table words are read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  // Table write port: clearing sweep or write-back
  assign tbl_we    = clr_active_r || (s1_adv && lock_we);
  assign tbl_waddr = clr_active_r ? clr_addr_r : req_addr;
  assign tbl_wdata = clr_active_r ? lgrt_entry_t'('0) : ent_nxt;

  lgrt_ram #(
    .WIDTH ($bits(lgrt_entry_t)),
    .DEPTH (LOCK_COUNT)
  ) u_lock_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (in_accept),
    .raddr (LOCK_AW'(in_data.lock_index)),
    .rdata (ent)
  );

  lgrt_ram #(
    .WIDTH ($bits(lgrt_row_t)),
    .DEPTH (LOCK_COUNT)
  ) u_waiter_tbl (
    .clk   (clk),
    .we    (s1_adv && row_we),
    .waddr (req_addr),
    .wdata (row_nxt),
    .re    (in_accept),
    .raddr (LOCK_AW'(in_data.lock_index)),
    .rdata (row)
  );

  // Request decode
  assign who      = req_r.client[CW-1:0];
  assign idx_ok   = 32'(req_r.lock_index) < LOCK_COUNT;
  assign req_addr = LOCK_AW'(req_r.lock_index);

  // FIFO slot arithmetic: tail for enqueue, next head for dequeue
  always_comb begin
    enq_sum  = SUM_W'(ent.head) + SUM_W'(ent.count);
    deq_sum  = SUM_W'(ent.head) + SUM_W'(1);
    enq_slot = (enq_sum >= SUM_W'(WAIT_DEPTH)) ? HEAD_W'(enq_sum - SUM_W'(WAIT_DEPTH))
                                               : HEAD_W'(enq_sum);
    deq_head = (deq_sum >= SUM_W'(WAIT_DEPTH)) ? HEAD_W'(deq_sum - SUM_W'(WAIT_DEPTH))
                                               : HEAD_W'(deq_sum);
  end

  // Decide the result and the new table words
  always_comb begin
    ent_nxt = ent;
    row_nxt = row;
    lock_we = 1'b0;
    row_we  = 1'b0;
    res     = '0;
    if (!idx_ok) begin
      res.status = STATUS_NO_LOCK;
    end else begin
      case (req_r.kind)
        KIND_ACQUIRE: begin
          lock_we       = 1'b1;
          ent_nxt.known = 1'b1;
          if (ent.held) begin
            res.status = STATUS_RETRY;
            if (!ent.pending) begin
              ent_nxt.pending   = 1'b1;
              res.revoke_valid  = 1'b1;
              res.revoke_client = 8'(ent.holder);
            end
            if (ent.count < CNT_W'(WAIT_DEPTH)) begin
              row_nxt[enq_slot] = who;
              row_we            = 1'b1;
              ent_nxt.count     = ent.count + 1'b1;
            end else begin
              res.queue_full = 1'b1;
            end
          end else begin
            res.status     = STATUS_OK;
            ent_nxt.held   = 1'b1;
            ent_nxt.holder = who;
            if (ent.count != '0) begin
              ent_nxt.pending   = 1'b1;
              res.revoke_valid  = 1'b1;
              res.revoke_client = 8'(who);
            end
          end
        end
        KIND_RELEASE: begin
          if (!ent.known) begin
            res.status = STATUS_NO_LOCK;
          end else if (!ent.held) begin
            res.status = STATUS_FREE;
          end else begin
            lock_we         = 1'b1;
            res.status      = STATUS_OK;
            ent_nxt.held    = 1'b0;
            ent_nxt.pending = 1'b0;
            if (ent.count != '0) begin
              res.retry_valid  = 1'b1;
              res.retry_client = 8'(row[ent.head]);
              ent_nxt.head     = deq_head;
              ent_nxt.count    = ent.count - 1'b1;
            end
          end
        end
        KIND_STAT: begin
          lock_we       = 1'b1;
          ent_nxt.known = 1'b1;
          res.status    = STATUS_OK;
          res.locked    = ent.held;
        end
        default: begin
          res.status = STATUS_OK;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // No request is taken while the clearing sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_accept)
    else $error("item accepted during table clear");

  // An accepted item occupies the compute stage next cycle and blocks intake
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (s1_valid_r && !in_ready))
    else $error("compute stage not loaded after accept");

  // Waiter count never exceeds the FIFO depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && lock_we) |-> (ent_nxt.count <= CNT_W'(WAIT_DEPTH)))
    else $error("waiter count overflow");

  // Revoke and retry never come from the same request
  a_msg_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.revoke_valid && out_r.retry_valid))
    else $error("revoke and retry in one result");

  // A full FIFO only ever answers retry
  a_full_retry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.queue_full) |-> (out_r.status == STATUS_RETRY))
    else $error("queue_full without retry status");
`endif

endmodule
